/* hw/rtl/psb_pkg.sv */
// shared types and constants of the percentile segment boundary unit
`timescale 1ns / 1ps
`default_nettype none

package psb_pkg;

	localparam int SCORE_W = 17;
	localparam int POS_W   = 32;
	localparam int RANK_W  = 7;
	localparam int SEGS_W  = 8;
	localparam int SAMP_W  = 16;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE_RANK     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE           = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SEGMENT_SAMPLES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENTS        = 2'd3;

	// register reset values
	localparam logic [RANK_W-1:0]  RST_PERCENTILE_RANK     = 7'd85;
	localparam logic [SCORE_W-1:0] RST_MIN_SCORE           = 17'd6553;
	localparam logic [SAMP_W-1:0]  RST_MIN_SEGMENT_SAMPLES = 16'd941;
	localparam logic [SEGS_W-1:0]  RST_MAX_SEGMENTS        = 8'd200;

	// floor(x / 100) as (x * 5243) >> 19, exact for x below 12800
	localparam int               RECIP_W    = 13;
	localparam logic [RECIP_W-1:0] RANK_RECIP = 13'd5243;
	localparam int               RANK_SHIFT = 19;

	typedef struct packed {
		logic [SCORE_W-1:0] frame_score;
		logic [POS_W-1:0]   sample_position;
	} psb_item_t;

	typedef struct packed {
		logic               boundary;
		logic               segment_closed;
		logic [POS_W-1:0]   seg_start;
		logic [POS_W-1:0]   seg_end;
		logic [SEGS_W-1:0]  segment_index;
		logic [SCORE_W-1:0] threshold;
	} psb_result_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic shift;
		logic load;
		logic rotate;
		logic collect;
	} psb_cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROTATE,
		ST_COLLECT,
		ST_DECIDE
	} psb_state_t;

endpackage

`default_nettype wire

/* hw/rtl/psb_cell.sv */
// one history cell: stored score, rotating copy, rank counters and result tap
`timescale 1ns / 1ps
`default_nettype none

module psb_cell #(
	parameter int CW = 7
) (
	input  wire                              clk,
	input  psb_pkg::psb_cell_ctrl_t          ctrl,
	input  wire                              valid,
	input  wire [CW-1:0]                     k,
	input  wire [psb_pkg::SCORE_W-1:0]       hist_in,
	output logic [psb_pkg::SCORE_W-1:0]      hist_out,
	input  wire [psb_pkg::SCORE_W-1:0]       trav_in,
	input  wire                              trav_v_in,
	output logic [psb_pkg::SCORE_W-1:0]      trav_out,
	output logic                             trav_v_out,
	input  wire [psb_pkg::SCORE_W-1:0]       res_in,
	output logic [psb_pkg::SCORE_W-1:0]      res_out
);

	logic [psb_pkg::SCORE_W-1:0] hist_q;
	logic [psb_pkg::SCORE_W-1:0] trav_q;
	logic                        trav_v_q;
	logic [CW-1:0]               below_q;
	logic [CW-1:0]               upto_q;
	logic [psb_pkg::SCORE_W-1:0] res_q;
	logic                        match;

	// this cell holds the k-th smallest value
	assign match = valid && (below_q <= k) && (k < upto_q);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			hist_q <= hist_in;
		end
		if (ctrl.load) begin
			trav_q   <= hist_q;
			trav_v_q <= valid;
			below_q  <= '0;
			upto_q   <= '0;
		end else if (ctrl.rotate) begin
			trav_q   <= trav_in;
			trav_v_q <= trav_v_in;
			if (trav_v_q && (trav_q < hist_q)) begin
				below_q <= below_q + CW'(1);
			end
			if (trav_v_q && (trav_q <= hist_q)) begin
				upto_q <= upto_q + CW'(1);
			end
		end
		if (ctrl.collect) begin
			res_q <= match ? hist_q : res_in;
		end
	end

	assign hist_out   = hist_q;
	assign trav_out   = trav_q;
	assign trav_v_out = trav_v_q;
	assign res_out    = res_q;

endmodule

`default_nettype wire

/* hw/rtl/percentile_segment_boundary_unit.sv */
// top level of the percentile segment boundary unit: sequencer, cell chain, decision
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                payload
// item      in         item_valid / item_stall    item   (psb_item_t)
// result    out        result_valid / result_stall result (psb_result_t)
// cfg       in         cfg_write                  cfg_index, cfg_data
//
// one item passes an accept step, a load step, a rotate pass that moves every
// score past every cell, a collect pass in which the matching value rides the
// result chain to the end, and a decision step. the next item is taken as soon
// as the unit is idle, even while the last result still sits in the output
// register; a stalled output only holds the unit in the decision state. reset
// clears control state and loads the register defaults; the history cells need
// no clearing, the fill count masks them

module percentile_segment_boundary_unit #(
	parameter int HISTORY_DEPTH = 100
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 item_valid,
	output logic                                item_stall,
	input  psb_pkg::psb_item_t                  item,
	output logic                                result_valid,
	input  wire                                 result_stall,
	output psb_pkg::psb_result_t                result,
	input  wire                                 cfg_write,
	input  wire [psb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [psb_pkg::CFG_W-1:0]            cfg_data
);

	// fill count width, rotation counter width, rank product width
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int RW = $clog2(HISTORY_DEPTH);
	localparam int PW = psb_pkg::RANK_W + CW;
	localparam int FW = PW + psb_pkg::RECIP_W;
	localparam int QW = FW - psb_pkg::RANK_SHIFT;
	localparam int MW = (QW > CW) ? QW : CW;

	// configuration registers
	logic [psb_pkg::RANK_W-1:0]  rank_q;
	logic [psb_pkg::SCORE_W-1:0] min_score_q;
	logic [psb_pkg::SAMP_W-1:0]  min_samples_q;
	logic [psb_pkg::SEGS_W-1:0]  max_segs_q;

	// detector state
	logic [CW-1:0]               count_q;
	logic                        in_seg_q;
	logic [psb_pkg::POS_W-1:0]   seg_start_q;
	logic [psb_pkg::POS_W-1:0]   last_chg_q;
	logic [psb_pkg::SEGS_W-1:0]  seg_count_q;

	// current transaction
	logic [psb_pkg::SCORE_W-1:0] score_q;
	logic [psb_pkg::POS_W-1:0]   pos_q;
	logic [PW-1:0]               prod_q;
	logic [CW-1:0]               k_q;
	logic [RW-1:0]               step_q;

	// output register
	logic                        out_valid_q;
	psb_pkg::psb_result_t        result_q;

	psb_pkg::psb_state_t         state_q;
	psb_pkg::psb_state_t         state_d;
	psb_pkg::psb_cell_ctrl_t     cell_ctrl;

	logic                        accept;
	logic                        step_last;
	logic                        decide_fire;

	// cell chain wiring
	logic [psb_pkg::SCORE_W-1:0] hist_w   [HISTORY_DEPTH];
	logic [psb_pkg::SCORE_W-1:0] trav_w   [HISTORY_DEPTH];
	logic                        trav_v_w [HISTORY_DEPTH];
	logic [psb_pkg::SCORE_W-1:0] res_w    [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0]    cell_valid;

	// rank index: floor(rank * count / 100), clamped to count - 1
	logic [FW-1:0]               quot_full;
	logic [MW-1:0]               quot_ext;
	logic [MW-1:0]               count_ext;
	logic [CW-1:0]               k_d;

	// decision
	logic [psb_pkg::SCORE_W-1:0] thr;
	logic [psb_pkg::POS_W-1:0]   elapsed;
	logic                        is_boundary;
	logic                        do_close;

	assign item_stall   = (state_q != psb_pkg::ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign step_last    = (step_q == RW'(HISTORY_DEPTH - 1));
	assign decide_fire  = (state_q == psb_pkg::ST_DECIDE) && (!out_valid_q || !result_stall);
	assign result_valid = out_valid_q;
	assign result       = result_q;

	assign quot_full = FW'(prod_q) * FW'(psb_pkg::RANK_RECIP);
	assign quot_ext  = MW'(quot_full[FW-1:psb_pkg::RANK_SHIFT]);
	assign count_ext = MW'(count_q);
	assign k_d       = (quot_ext >= count_ext) ? (count_q - CW'(1)) : CW'(quot_ext);

	// the matching score has reached the far end of the result chain
	assign thr         = res_w[HISTORY_DEPTH-1];
	assign elapsed     = pos_q - last_chg_q;
	assign is_boundary = (score_q > thr) && (score_q > min_score_q) &&
	                     (elapsed >= psb_pkg::POS_W'(min_samples_q));
	assign do_close    = is_boundary && in_seg_q && (seg_count_q < max_segs_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d           = state_q;
		cell_ctrl.shift   = 1'b0;
		cell_ctrl.load    = 1'b0;
		cell_ctrl.rotate  = 1'b0;
		cell_ctrl.collect = 1'b0;
		unique case (state_q)
			psb_pkg::ST_IDLE: begin
				if (accept) begin
					cell_ctrl.shift = 1'b1;
					state_d         = psb_pkg::ST_LOAD;
				end
			end
			psb_pkg::ST_LOAD: begin
				cell_ctrl.load = 1'b1;
				state_d        = psb_pkg::ST_ROTATE;
			end
			psb_pkg::ST_ROTATE: begin
				cell_ctrl.rotate = 1'b1;
				if (step_last) begin
					state_d = psb_pkg::ST_COLLECT;
				end
			end
			psb_pkg::ST_COLLECT: begin
				cell_ctrl.collect = 1'b1;
				if (step_last) begin
					state_d = psb_pkg::ST_DECIDE;
				end
			end
			psb_pkg::ST_DECIDE: begin
				if (decide_fire) begin
					state_d = psb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = psb_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q        <= psb_pkg::RST_PERCENTILE_RANK;
			min_score_q   <= psb_pkg::RST_MIN_SCORE;
			min_samples_q <= psb_pkg::RST_MIN_SEGMENT_SAMPLES;
			max_segs_q    <= psb_pkg::RST_MAX_SEGMENTS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				psb_pkg::REG_PERCENTILE_RANK:     rank_q        <= cfg_data[psb_pkg::RANK_W-1:0];
				psb_pkg::REG_MIN_SCORE:           min_score_q   <= cfg_data[psb_pkg::SCORE_W-1:0];
				psb_pkg::REG_MIN_SEGMENT_SAMPLES: min_samples_q <= cfg_data[psb_pkg::SAMP_W-1:0];
				psb_pkg::REG_MAX_SEGMENTS:        max_segs_q    <= cfg_data[psb_pkg::SEGS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// fill count, detector state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			in_seg_q    <= 1'b0;
			seg_start_q <= '0;
			last_chg_q  <= '0;
			seg_count_q <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (accept && (count_q != CW'(HISTORY_DEPTH))) begin
				count_q <= count_q + CW'(1);
			end
			// one counter walks both the rotate and the collect pass
			if (cell_ctrl.rotate || cell_ctrl.collect) begin
				step_q <= step_last ? '0 : (step_q + RW'(1));
			end else begin
				step_q <= '0;
			end
			if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (decide_fire) begin
				out_valid_q <= 1'b1;
				if (is_boundary) begin
					in_seg_q    <= 1'b1;
					seg_start_q <= pos_q;
					last_chg_q  <= pos_q;
				end
				if (do_close) begin
					seg_count_q <= seg_count_q + psb_pkg::SEGS_W'(1);
				end
			end
		end
	end

	// transaction payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			score_q <= item.frame_score;
			pos_q   <= item.sample_position;
		end
		if (cell_ctrl.load) begin
			prod_q <= PW'(rank_q) * PW'(count_q);
		end
		if (cell_ctrl.rotate && (step_q == '0)) begin
			k_q <= k_d;
		end
		if (decide_fire) begin
			result_q.boundary       <= is_boundary;
			result_q.segment_closed <= do_close;
			result_q.seg_start      <= do_close ? seg_start_q : '0;
			result_q.seg_end        <= do_close ? pos_q : '0;
			result_q.segment_index  <= do_close ? seg_count_q : '0;
			result_q.threshold      <= thr;
		end
	end

	// the chain: history shifts toward the tail on every accepted item, the
	// rotating copies form a ring, the result tap flows toward the tail
	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		assign cell_valid[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			psb_cell #(
				.CW (CW)
			) u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl),
				.valid      (cell_valid[i]),
				.k          (k_q),
				.hist_in    (item.frame_score),
				.hist_out   (hist_w[i]),
				.trav_in    (trav_w[HISTORY_DEPTH-1]),
				.trav_v_in  (trav_v_w[HISTORY_DEPTH-1]),
				.trav_out   (trav_w[i]),
				.trav_v_out (trav_v_w[i]),
				.res_in     ('0),
				.res_out    (res_w[i])
			);
		end else begin : g_body
			psb_cell #(
				.CW (CW)
			) u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl),
				.valid      (cell_valid[i]),
				.k          (k_q),
				.hist_in    (hist_w[i-1]),
				.hist_out   (hist_w[i]),
				.trav_in    (trav_w[i-1]),
				.trav_v_in  (trav_v_w[i-1]),
				.trav_out   (trav_w[i]),
				.trav_v_out (trav_v_w[i]),
				.res_in     (res_w[i-1]),
				.res_out    (res_w[i])
			);
		end
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench of the percentile segment boundary unit
`timescale 1ns / 1ps

module testbench;

	localparam int HIST_DEPTH   = 100;
	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 10;
	// time for one frame to pass through the unit, plus room for a stalled output
	localparam int DRAIN_CYCLES = 2 * HIST_DEPTH + 40;
	// slowest correct run is roughly 1200 frames
	localparam int CYCLE_LIMIT  = 2000000;

	// block ports, every input known from time zero
	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          item_valid   = 1'b0;
	logic                          item_stall;
	psb_pkg::psb_item_t            item         = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	psb_pkg::psb_result_t          result;
	logic                          cfg_write    = 1'b0;
	logic [psb_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [psb_pkg::CFG_W-1:0]     cfg_data     = '0;

	// frames waiting to be sent and decisions waiting to be seen
	psb_pkg::psb_item_t   pending_frames[$];
	psb_pkg::psb_result_t expected_decisions[$];

	int          error_count = 0;
	int unsigned cycle_count = 0;

	// predictor copy of the register file
	logic [psb_pkg::RANK_W-1:0]  cfg_rank     = psb_pkg::RST_PERCENTILE_RANK;
	logic [psb_pkg::SCORE_W-1:0] cfg_floor    = psb_pkg::RST_MIN_SCORE;
	logic [psb_pkg::SAMP_W-1:0]  cfg_gap      = psb_pkg::RST_MIN_SEGMENT_SAMPLES;
	logic [psb_pkg::SEGS_W-1:0]  cfg_max_segs = psb_pkg::RST_MAX_SEGMENTS;

	// predictor copy of the detector state
	logic [psb_pkg::SCORE_W-1:0] score_hist [HIST_DEPTH];
	int unsigned                 hist_wr    = 0;
	int unsigned                 hist_fill  = 0;
	logic                        seg_open   = 1'b0;
	logic [psb_pkg::POS_W-1:0]   seg_begin  = '0;
	logic [psb_pkg::POS_W-1:0]   last_cut   = '0;
	logic [psb_pkg::SEGS_W-1:0]  segs_done  = '0;

	// running position of the well-formed frame stream
	logic [psb_pkg::POS_W-1:0] stream_pos = '0;

	// sender burst shaping
	int burst_left = 0;
	int gap_left   = 0;

	// receiver stall pattern
	int stall_period = 1;
	int stall_len    = 0;
	int stall_phase  = 0;
	int pattern_left = 0;

	percentile_segment_boundary_unit #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// store the score, rank the history, then decide on a boundary
	function automatic psb_pkg::psb_result_t decide_frame(input psb_pkg::psb_item_t frame);
		psb_pkg::psb_result_t        dec;
		logic [psb_pkg::SCORE_W-1:0] ordered [HIST_DEPTH];
		logic [psb_pkg::SCORE_W-1:0] held;
		logic [psb_pkg::SCORE_W-1:0] thr;
		logic [psb_pkg::POS_W-1:0]   elapsed;
		int unsigned                 pick;
		int                          i;
		int                          j;
		dec = '0;
		score_hist[hist_wr] = frame.frame_score;
		hist_wr = (hist_wr + 1) % HIST_DEPTH;
		if (hist_fill < HIST_DEPTH) hist_fill++;

		// rank index, clamped to the top entry when the percentile is 100 or more
		pick = (cfg_rank * hist_fill) / 100;
		if (pick >= hist_fill) pick = hist_fill - 1;

		// the ring fills from entry 0, so the first hist_fill entries are the written ones
		for (i = 0; i < hist_fill; i++) ordered[i] = score_hist[i];
		for (i = 1; i < hist_fill; i++) begin
			held = ordered[i];
			j = i - 1;
			while (j >= 0 && ordered[j] > held) begin
				ordered[j + 1] = ordered[j];
				j--;
			end
			ordered[j + 1] = held;
		end
		thr = ordered[pick];
		dec.threshold = thr;

		if (frame.frame_score > thr && frame.frame_score > cfg_floor) begin
			// wrapping distance, so a position going backwards looks far away
			elapsed = frame.sample_position - last_cut;
			if (elapsed >= psb_pkg::POS_W'(cfg_gap)) begin
				dec.boundary = 1'b1;
				// close the open segment unless the segment budget is used up
				if (seg_open && segs_done < cfg_max_segs) begin
					dec.segment_closed = 1'b1;
					dec.seg_start      = seg_begin;
					dec.seg_end        = frame.sample_position;
					dec.segment_index  = segs_done;
					segs_done          = segs_done + 1'b1;
				end
				seg_begin = frame.sample_position;
				seg_open  = 1'b1;
				last_cut  = frame.sample_position;
			end
		end
		return dec;
	endfunction

	// sender: bursts of frame transactions with random gaps, payload held while stalled
	always @(posedge clk) begin
		logic               next_valid;
		psb_pkg::psb_item_t next_item;
		next_valid = item_valid;
		next_item  = item;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				expected_decisions.push_back(decide_frame(item));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_frames.size() != 0) begin
					next_item  = pending_frames.pop_front();
					next_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						// long gapless stretch
						gap_left   = 0;
						burst_left = $urandom_range(20, 80);
					end else begin
						gap_left   = $urandom_range(1, 15);
						burst_left = $urandom_range(1, 6);
					end
				end
			end
		end
		item_valid <= next_valid;
		item       <= next_item;
	end

	// receiver: periodic stall pattern that changes shape now and then
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			stall_period = $urandom_range(2, 9);
			// a quarter of the patterns never stall
			if ($urandom_range(0, 3) == 0) stall_len = 0;
			else stall_len = $urandom_range(1, stall_period - 1);
			pattern_left = $urandom_range(50, 400);
			stall_phase  = 0;
		end else begin
			pattern_left--;
		end
		result_stall <= (stall_phase < stall_len);
		stall_phase = (stall_phase + 1) % stall_period;
	end

	task automatic check_field(input string name, input logic [psb_pkg::POS_W-1:0] want,
			input logic [psb_pkg::POS_W-1:0] got);
		if (got !== want) begin
			error_count++;
			$error("%s expected 0x%0h actual 0x%0h", name, want, got);
		end
	endtask

	// monitor: every result transaction against the oldest pending decision
	always @(posedge clk) begin
		psb_pkg::psb_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_decisions.size() == 0) begin
				error_count++;
				$error("result transaction with no decision pending: 0x%0h", result);
			end else begin
				want = expected_decisions.pop_front();
				check_field("boundary", psb_pkg::POS_W'(want.boundary),
					psb_pkg::POS_W'(result.boundary));
				check_field("segment_closed", psb_pkg::POS_W'(want.segment_closed),
					psb_pkg::POS_W'(result.segment_closed));
				check_field("seg_start", want.seg_start, result.seg_start);
				check_field("seg_end", want.seg_end, result.seg_end);
				check_field("segment_index", psb_pkg::POS_W'(want.segment_index),
					psb_pkg::POS_W'(result.segment_index));
				check_field("threshold", psb_pkg::POS_W'(want.threshold),
					psb_pkg::POS_W'(result.threshold));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[percentile_segment_boundary_unit] ERROR");
			$finish;
		end
	end

	// register write, mirrored into the predictor, only while the unit is idle
	task automatic write_reg(input logic [psb_pkg::CFG_IDX_W-1:0] idx,
			input logic [psb_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			psb_pkg::REG_PERCENTILE_RANK:     cfg_rank     = val[psb_pkg::RANK_W-1:0];
			psb_pkg::REG_MIN_SCORE:           cfg_floor    = val[psb_pkg::SCORE_W-1:0];
			psb_pkg::REG_MIN_SEGMENT_SAMPLES: cfg_gap      = val[psb_pkg::SAMP_W-1:0];
			psb_pkg::REG_MAX_SEGMENTS:        cfg_max_segs = val[psb_pkg::SEGS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic push_frame(input logic [psb_pkg::SCORE_W-1:0] score,
			input logic [psb_pkg::POS_W-1:0] pos);
		psb_pkg::psb_item_t frame;
		frame.frame_score     = score;
		frame.sample_position = pos;
		pending_frames.push_back(frame);
	endtask

	// wait until every frame is sent and every decision has come back
	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_frames.size() != 0 || item_valid || expected_decisions.size() != 0);
	endtask

	// mostly a steady frame stream with onsets, some noise at arbitrary positions
	task automatic push_stream(input int count);
		logic [psb_pkg::SCORE_W-1:0] score;
		logic [psb_pkg::POS_W-1:0]   pos;
		int                          kind;
		int                          i;
		for (i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				score = psb_pkg::SCORE_W'($urandom());
				pos   = $urandom();
			end else begin
				if (kind < 14) stream_pos += $urandom_range(0, 70000);
				else stream_pos += $urandom_range(64, 512);
				pos = stream_pos;
				if (kind < 24) score = psb_pkg::SCORE_W'($urandom_range(20000, 65536));
				else if (kind < 28) score = psb_pkg::SCORE_W'($urandom_range(65537, 131071));
				else score = psb_pkg::SCORE_W'($urandom_range(0, 12000));
			end
			push_frame(score, pos);
		end
	endtask

	task automatic run_phase(input logic [psb_pkg::CFG_W-1:0] rank,
			input logic [psb_pkg::CFG_W-1:0] floor_val,
			input logic [psb_pkg::CFG_W-1:0] gap, input logic [psb_pkg::CFG_W-1:0] max_segs,
			input int count);
		wait_quiet();
		write_reg(psb_pkg::REG_PERCENTILE_RANK, rank);
		write_reg(psb_pkg::REG_MIN_SCORE, floor_val);
		write_reg(psb_pkg::REG_MIN_SEGMENT_SAMPLES, gap);
		write_reg(psb_pkg::REG_MAX_SEGMENTS, max_segs);
		@(negedge clk);
		stream_pos = $urandom();
		push_stream(count);
	endtask

	initial begin
		int p;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: quiet start, first onset, too-close onset, then a closed segment
		@(negedge clk);
		push_frame(17'd0, 32'd0);
		push_frame(17'd100, 32'd128);
		push_frame(17'd200, 32'd256);
		push_frame(17'd300, 32'd384);
		push_frame(17'd400, 32'd512);
		push_frame(17'd500, 32'd640);
		push_frame(17'd65536, 32'd2000);
		push_frame(17'd65536, 32'd2500);
		push_frame(17'h1FFFF, 32'd5000);
		push_frame(17'd50, 32'hFFFF_FFFF);

		// percentile above 100: threshold is the largest stored score
		wait_quiet();
		write_reg(psb_pkg::REG_PERCENTILE_RANK, psb_pkg::CFG_W'(127));
		@(negedge clk);
		push_frame(17'd70000, 32'h8000_0000);
		push_frame(17'd3, 32'h8000_0100);

		// lowest rank, widest spacing, budget already spent; position goes backwards
		wait_quiet();
		write_reg(psb_pkg::REG_PERCENTILE_RANK, psb_pkg::CFG_W'(0));
		write_reg(psb_pkg::REG_MIN_SCORE, psb_pkg::CFG_W'(0));
		write_reg(psb_pkg::REG_MIN_SEGMENT_SAMPLES, psb_pkg::CFG_W'(65535));
		write_reg(psb_pkg::REG_MAX_SEGMENTS, psb_pkg::CFG_W'(1));
		@(negedge clk);
		push_frame(17'd1, 32'h0000_0010);
		push_frame(17'd2, 32'h0000_0020);
		push_frame(17'd9, 32'h0001_0010);

		// budget reopened, no spacing: a segment closes again, a zero score never wins
		wait_quiet();
		write_reg(psb_pkg::REG_MIN_SEGMENT_SAMPLES, psb_pkg::CFG_W'(0));
		write_reg(psb_pkg::REG_MAX_SEGMENTS, psb_pkg::CFG_W'(255));
		@(negedge clk);
		push_frame(17'd5, 32'h0001_0011);
		push_frame(17'd0, 32'h0001_0100);

		// random phases, extremes first; a boundary on nearly every frame fills the budget
		run_phase(psb_pkg::CFG_W'(0), psb_pkg::CFG_W'(0), psb_pkg::CFG_W'(0),
			psb_pkg::CFG_W'(255), 260);
		run_phase(psb_pkg::CFG_W'(85), psb_pkg::CFG_W'(6553), psb_pkg::CFG_W'(941),
			psb_pkg::CFG_W'(200), 150);
		run_phase(psb_pkg::CFG_W'(100), psb_pkg::CFG_W'(131071), psb_pkg::CFG_W'(65535),
			psb_pkg::CFG_W'(0), 60);
		run_phase(psb_pkg::CFG_W'(50), psb_pkg::CFG_W'(65536), psb_pkg::CFG_W'(300),
			psb_pkg::CFG_W'(0), 100);
		for (p = 0; p < 5; p++) begin
			run_phase(psb_pkg::CFG_W'($urandom_range(0, 127)),
				psb_pkg::CFG_W'($urandom_range(0, 131071)),
				psb_pkg::CFG_W'($urandom_range(0, 2000)),
				psb_pkg::CFG_W'($urandom_range(0, 255)), 120);
		end

		// drain, then let the unit run out its latency to catch stray results
		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("[percentile_segment_boundary_unit] OK");
		end else begin
			$display("[percentile_segment_boundary_unit] ERROR");
		end
		$finish;
	end

endmodule
